// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Depends on nothing; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: hw/rtl/mmbf_pkg.sv
// Shared types and constants of the mipmap box filter packer.
// Depends on nothing.
package mmbf_pkg;
  localparam int unsigned REG_PIXEL_FORMAT = 0;
  localparam int unsigned REG_LOG2_WIDTH   = 1;
  localparam int unsigned REG_LOG2_HEIGHT  = 2;
  localparam int unsigned REG_GENERATE     = 3;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [3:0]  level;
    logic [26:0] byte_address;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic        last_of_run;
  } result_t;

  // Settings a cell needs, broadcast along the chain.
  typedef struct packed {
    logic       fmt;
    logic [3:0] lw;
    logic [3:0] lh;
    logic [3:0] nlev;
    logic       restart;
  } ctl_t;

  // Token handed from one cell to the next.
  typedef struct packed {
    logic   vld;
    pixel_t px;
    logic [26:0] off;
    logic [12:0] poff;
  } tok_t;
endpackage

// File: hw/rtl/mmbf_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface mmbf_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/mipmap_chain_box_filter_packer_core.sv
// Top level of the mipmap box filter packer: config, cell chain, output.
// Depends on mmbf_pkg, mmbf_if, mmbf_cell and assert_macros.svh.
//
// Usage: base pixels enter on the in_ channel in raster order, one request
// per pixel. Each request yields its level-0 pixel and, when generation is
// on and a 2x2 block of some level completes, one pixel per finished
// level, in level order; last_of_run marks the final one of the request.
// The chain has one cell per level. A request enters cell 0; each cell
// emits its level's result in the cycle it holds the token and, when its
// block completes, hands the averaged pixel to the next cell on the next
// cycle. A request is accepted, then yields one result per cycle while the
// receiver does not stall; its first result enters the output register
// when cell 0 advances the token. The next request is taken once the last
// result has moved into the output register. Results leave through a
// one-entry output register; a stalled receiver holds the chain in place.
// Reset clears the counters, config, busy and output-valid flags; the
// pair-sum rows need no clearing since a frame writes each entry before
// reading. Any listed register write restarts the frame counters.
`include "assert_macros.svh"
module mipmap_chain_box_filter_packer_core #(
  parameter int unsigned MAX_LOG2_SIZE = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  mmbf_if.sink        in_ch,
  mmbf_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import mmbf_pkg::*;
  localparam int unsigned NL = MAX_LOG2_SIZE + 1;
  localparam int unsigned SW = $clog2(NL + 1);

  logic       fmt_r, gen_r;
  logic [3:0] lw_r, lh_r, lwc, lhc, mn;
  ctl_t       ctl;
  tok_t       tok_r, tok_nxt;
  logic [SW-1:0] lvl_r;
  logic       busy_r;
  tok_t       tin [NL];
  tok_t       tout [NL];
  result_t    res [NL];
  logic [NL-1:0] rv;
  result_t    sel;
  logic       ov_r;
  result_t    od_r;
  logic       adv;

  assign lwc = (lw_r > 4'(MAX_LOG2_SIZE)) ? 4'(MAX_LOG2_SIZE) : lw_r;
  assign lhc = (lh_r > 4'(MAX_LOG2_SIZE)) ? 4'(MAX_LOG2_SIZE) : lh_r;
  assign mn  = (lwc < lhc) ? lwc : lhc;
  assign ctl.fmt = fmt_r;
  assign ctl.lw  = lwc;
  assign ctl.lh  = lhc;
  assign ctl.nlev = gen_r ? mn + 4'd1 : 4'd1;
  assign ctl.restart = cfg_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 1'b0;
      lw_r <= '0;
      lh_r <= '0;
      gen_r <= 1'b0;
    end else if (cfg_we) begin
      case (32'(cfg_index))
        REG_PIXEL_FORMAT: fmt_r <= cfg_data[0];
        REG_LOG2_WIDTH:   lw_r <= cfg_data;
        REG_LOG2_HEIGHT:  lh_r <= cfg_data;
        REG_GENERATE:     gen_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // One active token at a time; lvl_r says which cell holds it.
  assign adv = busy_r && (!ov_r || out_ch.ready);
  assign in_ch.ready = !busy_r;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      tin[i] = tok_r;
      tin[i].vld = adv && (lvl_r == SW'(i));
    end
  end

  genvar g;
  generate
    for (g = 0; g < NL; g++) begin : g_cell
      mmbf_cell #(.LVL(g), .MAXL(MAX_LOG2_SIZE)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .tin(tin[g]),
        .tout(tout[g]), .res(res[g]), .res_vld(rv[g])
      );
    end
  endgenerate

  always_comb begin
    sel = res[0];
    tok_nxt = tout[0];
    for (int i = 0; i < NL; i++) begin
      if (lvl_r == SW'(i)) begin
        sel = res[i];
        tok_nxt = tout[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      lvl_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (in_ch.valid && !busy_r) begin
        busy_r <= 1'b1;
        lvl_r <= '0;
      end else if (adv) begin
        busy_r <= tok_nxt.vld;
        lvl_r <= lvl_r + 1'b1;
      end
      // output register: loaded on advance, emptied when taken
      if (adv) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && !busy_r) begin
      tok_r.px <= in_ch.data;
      tok_r.off <= '0;
      tok_r.poff <= '0;
      tok_r.vld <= 1'b1;
    end else if (adv) begin
      tok_r <= tok_nxt;
      od_r <= sel;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;

  `ASSERT_IMP(a_one_token, clk, rst_n, 1'b1, $onehot0(rv))
  `ASSERT_IMP(a_no_take_busy, clk, rst_n, busy_r, !in_ch.ready)
  `ASSERT_NEXT(a_hold_out, clk, rst_n, ov_r && !out_ch.ready, ov_r && $stable(od_r))
endmodule

// File: hw/rtl/mmbf_cell.sv
// One mip level of the chain: counters, pending left pixel, pair-sum row.
// Depends on mmbf_pkg.
module mmbf_cell #(
  parameter int unsigned LVL = 0,
  parameter int unsigned MAXL = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mmbf_pkg::ctl_t  ctl,
  input  mmbf_pkg::tok_t  tin,
  output mmbf_pkg::tok_t  tout,
  output mmbf_pkg::result_t res,
  output logic            res_vld
);
  import mmbf_pkg::*;
  localparam int unsigned DEPTH = (MAXL > LVL) ? (1 << (MAXL - LVL - 1)) : 1;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [MAXL-1:0] x_r, y_r, x_nxt, y_nxt;
  logic [2*MAXL-1:0] idx_r, idx_nxt;
  pixel_t left_r;
  logic [35:0] mem [DEPTH];
  logic [3:0] lwl, lhl;
  logic [MAXL:0] wl, hl;
  logic [2*MAXL:0] npix;
  logic [29:0] lsize;
  logic [35:0] pair, stored_r;
  logic [AW-1:0] pos;
  logic fwd, go;
  pixel_t avg;

  assign lwl  = ctl.lw - 4'(LVL);
  assign lhl  = ctl.lh - 4'(LVL);
  assign wl   = (MAXL+1)'(1) << lwl;
  assign hl   = (MAXL+1)'(1) << lhl;
  assign npix = (2*MAXL+1)'(1) << (5'(lwl) + 5'(lhl));
  assign go   = tin.vld && (4'(LVL) < ctl.nlev);
  assign pos  = AW'(x_r >> 1);

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      pair[9*c +: 9] = 9'(left_r[8*c +: 8]) + 9'(tin.px[8*c +: 8]);
    end
  end
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic [9:0] s;
      s = 10'(stored_r[9*c +: 9]) + 10'(pair[9*c +: 9]);
      avg[8*c +: 8] = s[9:2];
    end
  end

  always_comb begin
    x_nxt = x_r + 1'b1;
    y_nxt = y_r;
    if (({1'b0, x_r} + (MAXL+1)'(1)) >= wl) begin
      x_nxt = '0;
      y_nxt = y_r + 1'b1;
      if (({1'b0, y_r} + (MAXL+1)'(1)) >= hl) y_nxt = '0;
    end
    idx_nxt = idx_r + 1'b1;
    if (({1'b0, idx_r} + (2*MAXL+1)'(1)) >= npix) idx_nxt = '0;
  end

  assign fwd   = go && (4'(LVL + 1) < ctl.nlev) && x_r[0] && y_r[0];
  assign lsize = ctl.fmt ? 30'(npix) << 2 : 30'(npix) * 30'd3;

  always_comb begin
    res_vld            = go;
    res.level          = 4'(LVL);
    res.byte_address   = tin.off + (ctl.fmt ? 27'(idx_r) << 2 : 27'(idx_r) * 27'd3);
    res.out_red        = tin.px.red;
    res.out_green      = tin.px.green;
    res.out_blue       = tin.px.blue;
    res.out_alpha      = ctl.fmt ? tin.px.alpha : 8'd0;
    res.last_of_run    = !fwd;
    tout.vld  = fwd;
    tout.px   = avg;
    tout.off  = tin.off + 27'(lsize);
    tout.poff = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.restart) begin
      x_r <= '0;
      y_r <= '0;
      idx_r <= '0;
    end else if (go) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      idx_r <= idx_nxt;
    end
  end

  // Row entry is read into a register at the current column; the top never
  // hands a cell tokens on two adjacent cycles, so the data is ready in time.
  always_ff @(posedge clk) begin
    if (go && !x_r[0]) left_r <= tin.px;
    if (go && x_r[0] && !y_r[0]) mem[pos] <= pair;
    stored_r <= mem[pos];
  end
endmodule
